FILE: rtl/rcea_pkg.sv
// shared constants and types for the range count-and-assign block
// no dependencies
package rcea_pkg;

  localparam int IDX_W = 10;
  localparam int VAL_W = 32;
  localparam int CNT_W = 11;
  localparam logic [CNT_W-1:0] CNT_MAX = '1;

  typedef enum logic [3:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_DIV,
    ST_TAG_RD,
    ST_TAG_CHK,
    ST_SCAN,
    ST_FILL,
    ST_WALK,
    ST_DONE
  } rcea_state_t;

  typedef struct packed {
    logic capture;
    logic div;
    logic tag_rd;
    logic tag_set;
    logic tag_clr;
    logic cnt_blk;
    logic ptr_ld_s;
    logic ptr_ld_a;
    logic ptr_inc;
    logic elem_rd;
    logic elem_wr;
    logic fill;
    logic blk_inc;
    logic out_load;
    logic clr_wr;
  } rcea_cmd_t;

  typedef struct packed {
    logic empty;
    logic full;
    logic tag_vld;
    logic last_blk;
    logic ptr_at_e;
    logic ptr_at_z;
    logic is_query;
    logic clr_last;
    logic out_busy;
  } rcea_stat_t;

endpackage

FILE: rtl/rcea_ram.sv
// generic simple dual-port ram, one write and one registered read per cycle
// read returns the old contents on a same-address write; no dependencies
module rcea_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 1024
) (
  input  logic                                       clk,
  input  logic                                       wr_en,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] wr_addr,
  input  logic [WIDTH-1:0]                           wr_data,
  input  logic                                       rd_en,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] rd_addr,
  output logic [WIDTH-1:0]                           rd_data
);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [WIDTH-1:0] rd_data_r;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem_r[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data_r <= mem_r[rd_addr];
    end
  end

  assign rd_data = rd_data_r;

endmodule

FILE: rtl/rcea_ctrl.sv
// sequencer for loads, range queries and the tag clearing pass after reset
// uses rcea_pkg command and status types
module rcea_ctrl (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_stall,
  input  rcea_pkg::rcea_stat_t stat,
  output rcea_pkg::rcea_cmd_t  cmd
);

  rcea_pkg::rcea_state_t state_r, state_nxt;
  logic adv;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= rcea_pkg::ST_CLEAR;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    cmd       = '0;
    state_nxt = state_r;
    in_stall  = 1'b1;
    adv       = 1'b0;
    case (state_r)
      rcea_pkg::ST_CLEAR: begin
        cmd.clr_wr = 1'b1;
        if (stat.clr_last) begin
          state_nxt = rcea_pkg::ST_IDLE;
        end
      end
      rcea_pkg::ST_IDLE: begin
        in_stall = 1'b0;
        if (in_valid) begin
          cmd.capture = 1'b1;
          state_nxt   = rcea_pkg::ST_DIV;
        end
      end
      rcea_pkg::ST_DIV: begin
        cmd.div = 1'b1;
        if (stat.empty) begin
          state_nxt = rcea_pkg::ST_DONE;
        end else begin
          state_nxt = rcea_pkg::ST_TAG_RD;
        end
      end
      rcea_pkg::ST_TAG_RD: begin
        cmd.tag_rd = 1'b1;
        state_nxt  = rcea_pkg::ST_TAG_CHK;
      end
      rcea_pkg::ST_TAG_CHK: begin
        if (stat.full && stat.tag_vld) begin
          cmd.tag_set = 1'b1;
          cmd.cnt_blk = 1'b1;
          adv         = 1'b1;
        end else if (stat.full) begin
          cmd.ptr_ld_s = 1'b1;
          state_nxt    = rcea_pkg::ST_SCAN;
        end else if (stat.tag_vld) begin
          cmd.ptr_ld_s = 1'b1;
          cmd.cnt_blk  = 1'b1;
          state_nxt    = rcea_pkg::ST_FILL;
        end else begin
          cmd.ptr_ld_a = 1'b1;
          state_nxt    = rcea_pkg::ST_WALK;
        end
      end
      rcea_pkg::ST_SCAN: begin
        cmd.elem_rd = 1'b1;
        cmd.ptr_inc = 1'b1;
        if (stat.ptr_at_e) begin
          cmd.tag_set = 1'b1;
          adv         = 1'b1;
        end
      end
      rcea_pkg::ST_FILL: begin
        cmd.elem_wr = 1'b1;
        cmd.fill    = 1'b1;
        cmd.ptr_inc = 1'b1;
        if (stat.ptr_at_e) begin
          cmd.tag_clr = 1'b1;
          adv         = 1'b1;
        end
      end
      rcea_pkg::ST_WALK: begin
        cmd.elem_rd = 1'b1;
        cmd.elem_wr = 1'b1;
        cmd.ptr_inc = 1'b1;
        if (stat.ptr_at_z) begin
          adv = 1'b1;
        end
      end
      rcea_pkg::ST_DONE: begin
        if (!stat.is_query) begin
          state_nxt = rcea_pkg::ST_IDLE;
        end else if (!stat.out_busy) begin
          cmd.out_load = 1'b1;
          state_nxt    = rcea_pkg::ST_IDLE;
        end
      end
      default: begin
        state_nxt = rcea_pkg::ST_IDLE;
      end
    endcase

    if (adv) begin
      if (stat.last_blk) begin
        state_nxt = rcea_pkg::ST_DONE;
      end else begin
        cmd.blk_inc = 1'b1;
        state_nxt   = rcea_pkg::ST_TAG_RD;
      end
    end
  end

endmodule

FILE: rtl/rcea_dp.sv
// datapath: item registers, block index math, walk pointer, match counter,
// element and tag memories, result register; uses rcea_pkg and rcea_ram
module rcea_dp #(
  parameter int DEPTH     = 1024,
  parameter int BLOCK_LEN = 32
) (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              in_func,
  input  logic [rcea_pkg::IDX_W-1:0]        in_load_index,
  input  logic signed [rcea_pkg::VAL_W-1:0] in_load_value,
  input  logic [rcea_pkg::IDX_W-1:0]        in_left_index,
  input  logic [rcea_pkg::IDX_W-1:0]        in_right_index,
  input  logic signed [rcea_pkg::VAL_W-1:0] in_key,
  input  logic                              out_stall,
  output logic                              out_valid,
  output logic [rcea_pkg::CNT_W-1:0]        out_match_count,
  input  rcea_pkg::rcea_cmd_t               cmd,
  output rcea_pkg::rcea_stat_t              stat
);

  localparam int IDX_W = rcea_pkg::IDX_W;
  localparam int VAL_W = rcea_pkg::VAL_W;
  localparam int CNT_W = rcea_pkg::CNT_W;
  localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int NB    = (DEPTH + BLOCK_LEN - 1) / BLOCK_LEN;
  localparam int BW    = (NB > 1) ? $clog2(NB) : 1;
  localparam int EW0   = $clog2(DEPTH + BLOCK_LEN);
  localparam int EW    = (EW0 > IDX_W) ? EW0 : IDX_W;
  localparam int SHIFT = IDX_W + $clog2(BLOCK_LEN);
  localparam int RW    = IDX_W + 2;
  localparam int PW    = IDX_W + RW;
  localparam int ADDW  = $clog2(BLOCK_LEN + 1);
  localparam logic [RW-1:0] RECIP    = RW'((1 << SHIFT) / BLOCK_LEN + 1);
  localparam logic [EW-1:0] LAST_IDX = EW'(DEPTH - 1);
  localparam logic [BW-1:0] LAST_BLK = BW'(NB - 1);

  logic             func_r;
  logic [EW-1:0]    lo_r, hi_r;
  logic [VAL_W-1:0] key_r;
  logic [BW-1:0]    blk_r, last_blk_r;
  logic [EW-1:0]    s_r, e_r;
  logic [EW-1:0]    ptr_r;
  logic [CNT_W-1:0] cnt_r;
  logic             rd_vld_r;
  logic [BW-1:0]    clr_r;
  logic             out_valid_r;
  logic [CNT_W-1:0] out_cnt_r;

  logic [EW-1:0]    lo_cap, hi_raw, hi_cap;
  logic [PW-1:0]    lo_prod, hi_prod;
  logic [EW-1:0]    s_calc, e_raw, e_calc;
  logic [EW-1:0]    a_w, z_w;
  logic             full_w, in_az;
  logic [VAL_W:0]   tag_q;
  logic [VAL_W-1:0] tag_val;
  logic             tag_match;
  logic [ADDW-1:0]  blk_add;
  logic [CNT_W:0]   cnt_sum;
  logic [CNT_W-1:0] cnt_nxt;
  logic [VAL_W-1:0] elem_q, elem_wdata;
  logic             tag_we;
  logic [BW-1:0]    tag_waddr;
  logic [VAL_W:0]   tag_wdata;

  // item capture, loads become a single-element range
  assign lo_cap = in_func ? EW'(in_left_index) : EW'(in_load_index);
  assign hi_raw = in_func ? EW'(in_right_index) : EW'(in_load_index);
  assign hi_cap = (hi_raw > LAST_IDX) ? LAST_IDX : hi_raw;

  // block index by reciprocal multiply
  assign lo_prod = PW'(lo_r[IDX_W-1:0]) * PW'(RECIP);
  assign hi_prod = PW'(hi_r[IDX_W-1:0]) * PW'(RECIP);

  // block bounds
  assign s_calc = EW'(blk_r) * EW'(BLOCK_LEN);
  assign e_raw  = s_calc + EW'(BLOCK_LEN - 1);
  assign e_calc = (e_raw > LAST_IDX) ? LAST_IDX : e_raw;

  assign a_w    = (lo_r > s_r) ? lo_r : s_r;
  assign z_w    = (hi_r < e_r) ? hi_r : e_r;
  assign full_w = (lo_r <= s_r) && (hi_r >= e_r);
  assign in_az  = (ptr_r >= a_w) && (ptr_r <= z_w);

  assign tag_val   = tag_q[VAL_W-1:0];
  assign tag_match = (tag_val == key_r);

  // match counter, saturating
  always_comb begin
    blk_add = '0;
    if (cmd.cnt_blk && tag_match) begin
      if (full_w) begin
        blk_add = ADDW'(e_r - s_r + EW'(1));
      end else begin
        blk_add = ADDW'(z_w - a_w + EW'(1));
      end
    end
    cnt_sum = (CNT_W+1)'(cnt_r) + (CNT_W+1)'(blk_add)
            + (CNT_W+1)'(rd_vld_r && (elem_q == key_r));
    if (cnt_sum > (CNT_W+1)'(rcea_pkg::CNT_MAX)) begin
      cnt_nxt = rcea_pkg::CNT_MAX;
    end else begin
      cnt_nxt = cnt_sum[CNT_W-1:0];
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      func_r <= in_func;
      lo_r   <= lo_cap;
      hi_r   <= hi_cap;
      key_r  <= in_func ? in_key : in_load_value;
      cnt_r  <= '0;
    end else begin
      cnt_r <= cnt_nxt;
    end
    if (cmd.div) begin
      blk_r      <= BW'(lo_prod >> SHIFT);
      last_blk_r <= BW'(hi_prod >> SHIFT);
    end else if (cmd.blk_inc) begin
      blk_r <= blk_r + BW'(1);
    end
    if (cmd.tag_rd) begin
      s_r <= s_calc;
      e_r <= e_calc;
    end
    if (cmd.ptr_ld_s) begin
      ptr_r <= s_r;
    end else if (cmd.ptr_ld_a) begin
      ptr_r <= a_w;
    end else if (cmd.ptr_inc) begin
      ptr_r <= ptr_r + EW'(1);
    end
    if (cmd.out_load) begin
      out_cnt_r <= cnt_nxt;
    end
  end

  // control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      rd_vld_r    <= 1'b0;
      clr_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      rd_vld_r <= cmd.elem_rd;
      if (cmd.clr_wr) begin
        clr_r <= clr_r + BW'(1);
      end
      if (cmd.out_load) begin
        out_valid_r <= 1'b1;
      end else if (!out_stall) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // element memory
  assign elem_wdata = (cmd.fill && !in_az) ? tag_val : key_r;

  rcea_ram #(
    .WIDTH (VAL_W),
    .DEPTH (DEPTH)
  ) u_elem_ram (
    .clk     (clk),
    .wr_en   (cmd.elem_wr),
    .wr_addr (AW'(ptr_r)),
    .wr_data (elem_wdata),
    .rd_en   (cmd.elem_rd),
    .rd_addr (AW'(ptr_r)),
    .rd_data (elem_q)
  );

  // tag memory, {valid, value}
  assign tag_we    = cmd.clr_wr || cmd.tag_set || cmd.tag_clr;
  assign tag_waddr = cmd.clr_wr ? clr_r : blk_r;
  assign tag_wdata = cmd.clr_wr ? '0 : {cmd.tag_set, key_r};

  rcea_ram #(
    .WIDTH (VAL_W + 1),
    .DEPTH (NB)
  ) u_tag_ram (
    .clk     (clk),
    .wr_en   (tag_we),
    .wr_addr (tag_waddr),
    .wr_data (tag_wdata),
    .rd_en   (cmd.tag_rd),
    .rd_addr (blk_r),
    .rd_data (tag_q)
  );

  assign stat.empty    = lo_r > hi_r;
  assign stat.full     = full_w;
  assign stat.tag_vld  = tag_q[VAL_W];
  assign stat.last_blk = (blk_r == last_blk_r);
  assign stat.ptr_at_e = (ptr_r == e_r);
  assign stat.ptr_at_z = (ptr_r == z_w);
  assign stat.is_query = func_r;
  assign stat.clr_last = (clr_r == LAST_BLK);
  assign stat.out_busy = out_valid_r && out_stall;

  assign out_valid       = out_valid_r;
  assign out_match_count = out_cnt_r;

endmodule

FILE: rtl/range_count_equal_then_assign.sv
// top level: range count-and-assign over block-tagged element storage
// instantiates rcea_ctrl and rcea_dp; uses rcea_pkg
//
//   channel   direction  handshake            payload
//   in_       input      in_valid / in_stall  func, load_index, load_value,
//                                             left_index, right_index, key
//   out_      output     out_valid/out_stall  match_count (queries only)
//
// per block touched an item reads and checks the tag; full untagged blocks are scanned
// element by element and partial tagged blocks are filled in full, while partial untagged
// blocks walk only the range elements; a load into a tagged block fills that whole block
// after reset a tag clearing pass over all DEPTH/BLOCK_LEN blocks (rounded up) holds in_stall high
// a new item is taken while a result waits in the output register; a query
// finishing before that result leaves holds in_stall high until it does
module range_count_equal_then_assign #(
  parameter int DEPTH     = 1024,
  parameter int BLOCK_LEN = 32
) (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              in_valid,
  output logic                              in_stall,
  input  logic                              in_func,
  input  logic [rcea_pkg::IDX_W-1:0]        in_load_index,
  input  logic signed [rcea_pkg::VAL_W-1:0] in_load_value,
  input  logic [rcea_pkg::IDX_W-1:0]        in_left_index,
  input  logic [rcea_pkg::IDX_W-1:0]        in_right_index,
  input  logic signed [rcea_pkg::VAL_W-1:0] in_key,
  output logic                              out_valid,
  input  logic                              out_stall,
  output logic [rcea_pkg::CNT_W-1:0]        out_match_count
);

  rcea_pkg::rcea_cmd_t  cmd;
  rcea_pkg::rcea_stat_t stat;

  rcea_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .stat     (stat),
    .cmd      (cmd)
  );

  rcea_dp #(
    .DEPTH     (DEPTH),
    .BLOCK_LEN (BLOCK_LEN)
  ) u_dp (
    .clk             (clk),
    .rst_n           (rst_n),
    .in_func         (in_func),
    .in_load_index   (in_load_index),
    .in_load_value   (in_load_value),
    .in_left_index   (in_left_index),
    .in_right_index  (in_right_index),
    .in_key          (in_key),
    .out_stall       (out_stall),
    .out_valid       (out_valid),
    .out_match_count (out_match_count),
    .cmd             (cmd),
    .stat            (stat)
  );

endmodule
